/* rtl/base64_stream_decoder_defines.svh */
// assertion macros shared by the base64 stream decoder rtl
// no dependencies; SYNTH selects the empty forms
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH
`define B64D_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define B64D_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop)
`define B64D_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/b64d_pkg.sv */
// types and constants of the base64 stream decoder
// used by the front, queue, back and top level

package b64d_pkg;

  localparam int unsigned SextetW = 6;
  localparam int unsigned AccumW  = 18;
  localparam int unsigned WordW   = 24;
  localparam int unsigned ByteW   = 8;

  localparam logic [ByteW-1:0] CharPlus  = 8'd43;
  localparam logic [ByteW-1:0] CharSlash = 8'h2f;
  localparam logic [ByteW-1:0] CharPad   = 8'h3d;

  // one decode job handed from front to back
  typedef struct packed {
    logic              bad;
    logic              fin;
    logic [1:0]        nbytes;
    logic [WordW-1:0]  word;
  } job_t;

endpackage

/* rtl/b64d_queue.sv */
// short job queue between decoder front and back
// depends on b64d_pkg and base64_stream_decoder_defines.svh
`include "base64_stream_decoder_defines.svh"

module b64d_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output b64d_pkg::job_t head_job_o,
  output logic           empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `B64D_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)
  `B64D_ASSERT_NEVER(a_cnt_in_range, clk_i, rst_ni, cnt_q > CntW'(Depth))

endmodule

/* rtl/b64d_front.sv */
// decoder front: takes characters, classifies them, tracks group state
// and issues decode jobs; depends on b64d_pkg and the defines header
`include "base64_stream_decoder_defines.svh"

module b64d_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     data_char_i,
  input  logic           is_final_i,
  input  logic           q_full_i,
  output logic           job_push_o,
  output b64d_pkg::job_t job_o
);
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    ClsData,
    ClsPad,
    ClsBad
  } cls_e;

  logic [1:0]        phase_q, phase_d;
  logic [AccumW-1:0] accum_q, accum_d;
  logic [1:0]        pad_q, pad_d;
  logic              err_q, err_d;
  logic              accept;
  cls_e              cls;
  logic [SextetW-1:0] val;
  logic [SextetW-1:0] v;
  logic [1:0]        pad_n;
  logic              raise_err;

  always_comb begin
    cls = ClsData;
    val = '0;
    if (data_char_i >= 8'h41 && data_char_i <= 8'h5a) begin
      val = SextetW'(data_char_i - 8'h41);
    end else if (data_char_i >= 8'h61 && data_char_i <= 8'h7a) begin
      val = SextetW'(data_char_i - 8'h61 + 8'd26);
    end else if (data_char_i >= 8'h30 && data_char_i <= 8'h39) begin
      val = SextetW'(data_char_i - 8'h30 + 8'd52);
    end else if (data_char_i == CharPlus) begin
      val = 6'd62;
    end else if (data_char_i == CharSlash) begin
      val = 6'd63;
    end else if (data_char_i == CharPad) begin
      cls = ClsPad;
    end else begin
      cls = ClsBad;
    end
  end

  assign accept = push_i && !q_full_i;
  assign v      = (cls == ClsPad) ? '0 : val;
  assign pad_n  = (cls == ClsPad) ? pad_q + 1'b1 : pad_q;

  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    pad_d      = pad_q;
    err_d      = err_q;
    job_push_o = 1'b0;
    job_o      = '0;
    raise_err  = 1'b0;
    if (accept) begin
      if (err_q) begin
        raise_err = is_final_i;
      end else if (cls == ClsBad) begin
        raise_err = 1'b1;
      end else if (cls == ClsPad && phase_q < 2'd2) begin
        raise_err = 1'b1;
      end else if (cls == ClsData && pad_q != 2'd0) begin
        raise_err = 1'b1;
      end else if (phase_q != 2'd3) begin
        accum_d   = {accum_q[AccumW-SextetW-1:0], v};
        phase_d   = phase_q + 1'b1;
        pad_d     = pad_n;
        raise_err = is_final_i;
      end else begin
        job_push_o   = 1'b1;
        job_o.word   = {accum_q, v};
        job_o.fin    = is_final_i;
        job_o.nbytes = (pad_n >= 2'd2) ? 2'd1 : ((pad_n == 2'd1) ? 2'd2 : 2'd3);
        phase_d      = '0;
        accum_d      = '0;
        pad_d        = pad_n;
      end
      if (raise_err) begin
        job_push_o   = 1'b1;
        job_o        = '0;
        job_o.bad    = 1'b1;
        job_o.fin    = is_final_i;
        job_o.nbytes = 2'd1;
        err_d        = 1'b1;
      end
      if (is_final_i) begin
        phase_d = '0;
        accum_d = '0;
        pad_d   = '0;
        err_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      accum_q <= '0;
      pad_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      pad_q   <= pad_d;
      err_q   <= err_d;
    end
  end

  `B64D_ASSERT_NEVER(a_pad_count_bound, clk_i, rst_ni, pad_q == 2'd3)
  `B64D_ASSERT(a_final_clears, clk_i, rst_ni,
               (accept && is_final_i) |=> (phase_q == 2'd0 && pad_q == 2'd0 && !err_q))

endmodule

/* rtl/b64d_back.sv */
// decoder back: splits queued jobs into result words and holds the
// output register; depends on b64d_pkg and the defines header
`include "base64_stream_decoder_defines.svh"

module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64d_pkg::job_t head_job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic           bad_input_o,
  output logic           run_last_o,
  output logic           string_done_o
);
  import b64d_pkg::*;

  logic [1:0]       idx_q, idx_d;
  logic             ov_q;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             bad_q, last_q, done_q;
  logic             last_d;
  logic             load;

  assign empty_o       = !ov_q;
  assign out_byte_o    = byte_q;
  assign bad_input_o   = bad_q;
  assign run_last_o    = last_q;
  assign string_done_o = done_q;

  assign load    = !q_empty_i && (!ov_q || pop_i);
  assign last_d  = head_job_i.bad || ((idx_q + 1'b1) == head_job_i.nbytes);
  assign q_pop_o = load && last_d;
  assign idx_d   = last_d ? '0 : idx_q + 1'b1;

  always_comb begin
    unique case (idx_q)
      2'd0:    byte_d = head_job_i.word[23:16];
      2'd1:    byte_d = head_job_i.word[15:8];
      default: byte_d = head_job_i.word[7:0];
    endcase
    if (head_job_i.bad) begin
      byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= idx_d;
      end else if (pop_i) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      bad_q  <= head_job_i.bad;
      last_q <= last_d;
      done_q <= last_d && head_job_i.fin;
    end
  end

  `B64D_ASSERT_NEVER(a_idx_in_job, clk_i, rst_ni,
                     !q_empty_i && !head_job_i.bad && idx_q >= head_job_i.nbytes)

endmodule

/* rtl/base64_stream_decoder.sv */
// base64 stream decoder, standard alphabet
// takes one character per word on the input queue interface and gives
// decoded bytes, one per word, on the result queue interface
// a final group of four gives three bytes, two or one when '=' pads it
// bad characters, misplaced '=', data after '=' or a short final group
// give one error word (byte 0, bad_input_o set); after that the string's
// characters are dropped until the final one, which gives one more error
// word with string_done_o set
// a taken character's job is written into the job queue, and the back then loads
// its words into the output register, once that register is empty or popped
// throughput: one character per cycle sustained while full is low; four
// characters give at most three words and the back emits one word per
// cycle while pop is high, so it keeps pace; full is high while the job
// queue (Depth entries) is full; if pop stays low the output register
// holds its word, the queue fills and full rises; nothing is lost
// reset empties the queue and the output register and clears group state
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back

module base64_stream_decoder #(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_char_i,
  input  logic       is_final_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       bad_input_o,
  output logic       run_last_o,
  output logic       string_done_o
);
  import b64d_pkg::*;

  job_t job;
  job_t head_job;
  logic job_push;
  logic q_empty;
  logic q_pop;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_char_i (data_char_i),
    .is_final_i  (is_final_i),
    .q_full_i    (full),
    .job_push_o  (job_push),
    .job_o       (job)
  );

  b64d_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_job_i (job),
    .full_o     (full),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .empty_o    (q_empty)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_job_i    (head_job),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .bad_input_o   (bad_input_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule

/* bench/testbench.sv */
// self-checking bench for base64_stream_decoder: directed strings, then random
// well-formed, broken and noise strings, checked word by word with random stalls
// depends on b64d_pkg and the decoder rtl
`timescale 1ns / 100ps

module testbench;
  import b64d_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned RandomChars = 190;
  localparam int unsigned PauseAt = 30;
  localparam int unsigned HoldAt = 60;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned CalmFrom = 120;
  localparam int unsigned CalmTo = 180;
  localparam int unsigned IdlePct = 13;
  localparam logic [6:0] SymInvalid = 7'd64;
  localparam logic [6:0] SymPad = 7'd65;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } in_char_t;

  typedef struct packed {
    logic [7:0] value;
    logic       bad;
    logic       last;
    logic       done;
  } dec_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_char_i = 8'h00;
  logic       is_final_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       bad_input_o;
  logic       run_last_o;
  logic       string_done_o;

  in_char_t    pending_chars[$];
  dec_word_t   due_words[$];
  int unsigned accepted_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        sink_hold = 1'b0;

  // decoder state as predicted
  logic [1:0]  grp_phase = 2'd0;
  logic [17:0] grp_accum = 18'd0;
  logic [1:0]  pad_seen = 2'd0;
  logic        err_seen = 1'b0;

  base64_stream_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_char_i  (data_char_i),
    .is_final_i   (is_final_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .bad_input_o  (bad_input_o),
    .run_last_o   (run_last_o),
    .string_done_o(string_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == CharPlus) return 7'd62;
    if (c == CharSlash) return 7'd63;
    if (c == CharPad) return SymPad;
    return SymInvalid;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return CharPlus;
    return CharSlash;
  endfunction

  task automatic clear_group();
    grp_phase = 2'd0;
    grp_accum = 18'd0;
    pad_seen = 2'd0;
    err_seen = 1'b0;
  endtask

  task automatic push_error(input logic fin);
    due_words.push_back('{8'h00, 1'b1, 1'b1, fin});
    if (fin) clear_group();
    else err_seen = 1'b1;
  endtask

  task automatic decode_char(input in_char_t it);
    logic [6:0]  sym;
    logic [23:0] grp;
    int          n;
    if (err_seen) begin
      if (it.fin) push_error(1'b1);
      return;
    end
    sym = sextet_of(it.ch);
    if (sym == SymInvalid) begin
      push_error(it.fin);
      return;
    end
    if (sym == SymPad) begin
      if (grp_phase < 2) begin
        push_error(it.fin);
        return;
      end
      pad_seen = pad_seen + 2'd1;
      sym = 7'd0;
    end else if (pad_seen != 0) begin
      push_error(it.fin);
      return;
    end
    if (grp_phase < 3) begin
      grp_accum = {grp_accum[11:0], sym[5:0]};
      grp_phase = grp_phase + 2'd1;
      if (it.fin) push_error(1'b1);
      return;
    end
    grp = {grp_accum, sym[5:0]};
    n = (pad_seen >= 2) ? 1 : ((pad_seen == 1) ? 2 : 3);
    for (int i = 0; i < n; i++) begin
      due_words.push_back('{grp[23-8*i -: 8], 1'b0, 1'(i == n - 1),
                            1'(i == n - 1) & it.fin});
    end
    grp_phase = 2'd0;
    grp_accum = 18'd0;
    if (it.fin) clear_group();
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch in %s: expected %0h, got %0h (cycle %0d)", what, exp_v, got_v,
             cycles);
    mismatches++;
  endtask

  task automatic add_char(input logic [7:0] c, input logic fin);
    pending_chars.push_back('{c, fin});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], 1'(i == s.len() - 1));
  endtask

  // random string, mostly well formed; returns the number of chars queued
  task automatic add_random_string(output int unsigned cnt);
    logic [7:0] chars[$];
    int         groups;
    int         pads;
    int         kind;
    int         pos;
    groups = $urandom_range(1, 4);
    pads = $urandom_range(0, 3);
    if (pads == 3) pads = 0;
    kind = $urandom_range(0, 99);
    for (int g = 0; g < groups; g++) begin
      for (int p = 0; p < 4; p++) begin
        if (g == groups - 1 && p >= 4 - pads) chars.push_back(CharPad);
        else chars.push_back(char_of(6'($urandom_range(0, 63))));
      end
    end
    if (kind < 10) begin
      // noise byte with random final mark
      chars.delete();
      add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      cnt = 1;
      return;
    end else if (kind < 20) begin
      pos = $urandom_range(0, chars.size() - 1);
      chars[pos] = 8'($urandom_range(0, 255));
    end else if (kind < 26) begin
      pos = $urandom_range(0, chars.size() - 1);
      chars[pos] = CharPad;
    end else if (kind < 32) begin
      pos = $urandom_range(1, 3);
      for (int i = 0; i < pos; i++) void'(chars.pop_back());
    end
    for (int i = 0; i < chars.size(); i++) add_char(chars[i], 1'(i == chars.size() - 1));
    cnt = chars.size();
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (pending_chars.size() != 0
                 && !(accepted_cnt == PauseAt && due_words.size() != 0)
                 && ((accepted_cnt >= CalmFrom && accepted_cnt < CalmTo)
                     || $urandom_range(0, 99) >= IdlePct)) begin
      push <= 1'b1;
      data_char_i <= pending_chars[0].ch;
      is_final_i <= pending_chars[0].fin;
    end else begin
      push <= 1'b0;
    end
  end

  // result side ready
  always @(negedge clk_i) begin
    if (!rst_ni || sink_hold) pop <= 1'b0;
    else pop <= (accepted_cnt >= CalmFrom && accepted_cnt < CalmTo)
                || $urandom_range(0, 99) >= IdlePct;
  end

  // monitor: predict on accepted chars, check accepted words
  always @(posedge clk_i) begin
    dec_word_t exp_w;
    if (rst_ni && push && !full) begin
      decode_char(pending_chars[0]);
      void'(pending_chars.pop_front());
      accepted_cnt++;
    end
    if (rst_ni && pop && !empty) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word, byte", 0, out_byte_o);
      end else begin
        exp_w = due_words.pop_front();
        if (out_byte_o !== exp_w.value) report_mismatch("out_byte", exp_w.value, out_byte_o);
        if (bad_input_o !== exp_w.bad) report_mismatch("bad_input", exp_w.bad, bad_input_o);
        if (run_last_o !== exp_w.last) report_mismatch("run_last", exp_w.last, run_last_o);
        if (string_done_o !== exp_w.done)
          report_mismatch("string_done", exp_w.done, string_done_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    while (accepted_cnt < HoldAt) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    int unsigned made;
    int unsigned cnt;
    add_text("TWFu");
    add_text("+/9=");
    add_text("TQ==");
    add_char(8'hFF, 1'b0);
    add_char("A", 1'b1);
    add_char(CharPad, 1'b1);
    add_text("A=");
    add_text("Zz");
    add_text("QQ=A");
    add_char(8'h00, 1'b1);
    made = 0;
    while (made < RandomChars) begin
      add_random_string(cnt);
      made += cnt;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_chars.size() != 0 || due_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_queue.sv
rtl/b64d_front.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
bench/testbench.sv
